@@ rtl/bbpa_pkg.sv @@
// Shared types, sizes and codes for the bitmap block pool allocator.
// No dependencies; every other file uses this package.
`default_nettype none

package bbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int MAX_BATCH  = 64;

    // Used map geometry: 32 blocks per map word.
    localparam int MAP_WORDS = (MAX_BLOCKS + 31) / 32;
    localparam int WSEL_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = WSEL_W + 5;

    // Fixed field widths.
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int TOTAL_W = 11;
    localparam int BATCH_W = 7;
    localparam int LIM_W   = TOTAL_W + SIZE_W;
    localparam int DSH_W   = SIZE_W + IDX_W;
    localparam int STEP_W  = $clog2(IDX_W);

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // Function codes.
    localparam logic [2:0] FN_ALLOC  = 3'd0;
    localparam logic [2:0] FN_FREE   = 3'd1;
    localparam logic [2:0] FN_RESET  = 3'd2;
    localparam logic [2:0] FN_BALLOC = 3'd3;
    localparam logic [2:0] FN_BFREE  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
    localparam logic [1:0] REG_BLOCK_TOTAL = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [SIZE_W-1:0]  size;   // zero already mapped to one
        logic [TOTAL_W-1:0] total;  // clamped to 1..MAX_BLOCKS
    } cfg_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [ADDR_W-1:0]  off;      // target minus base
        logic               bad_addr; // null or below base
        logic [BATCH_W-1:0] count;    // clamped to MAX_BATCH
        logic               last_elem;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/bbpa_if.sv @@
// Channel interfaces: request, result and configuration write.
// Depends on bbpa_pkg for field widths.
`default_nettype none

interface bbpa_req_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      func;
    logic [bbpa_pkg::ADDR_W-1:0]     target_address;
    logic [bbpa_pkg::BATCH_W-1:0]    batch_count;
    logic                            batch_end;
    modport source (output valid, func, target_address, batch_count, batch_end, input ready);
    modport sink   (input valid, func, target_address, batch_count, batch_end, output ready);
endinterface

interface bbpa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [bbpa_pkg::ADDR_W-1:0]     granted_address;
    logic [bbpa_pkg::TOTAL_W-1:0]    blocks_in_use;
    logic [bbpa_pkg::BATCH_W-1:0]    batch_total;
    logic                            run_last;
    modport source (output valid, ok, granted_address, blocks_in_use, batch_total, run_last,
                    input ready);
    modport sink   (input valid, ok, granted_address, blocks_in_use, batch_total, run_last,
                    output ready);
endinterface

interface bbpa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      index;
    logic [31:0]                     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/bbpa_front.sv @@
// Front end: configuration registers, request accept and classification.
// Depends on bbpa_pkg and bbpa_if.
`default_nettype none

module bbpa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bbpa_req_if.sink           req,
    bbpa_cfg_if.sink           cfg,
    output bbpa_pkg::cfg_t     cfg_eff,
    output bbpa_pkg::cmd_t     cmd,
    output logic               push,
    input  wire logic          full
);
    import bbpa_pkg::*;

    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [TOTAL_W-1:0] total_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= SIZE_W'(64);
            total_reg <= TOTAL_W'(1024);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_POOL_BASE:   base_reg  <= cfg.data;
                REG_BLOCK_BYTES: size_reg  <= cfg.data[SIZE_W-1:0];
                REG_BLOCK_TOTAL: total_reg <= cfg.data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg_eff.base = base_reg;
        cfg_eff.size = (size_reg == '0) ? SIZE_W'(1) : size_reg;
        if (total_reg == '0)
            cfg_eff.total = TOTAL_W'(1);
        else if (32'(total_reg) > 32'(MAX_BLOCKS))
            cfg_eff.total = TOTAL_W'(MAX_BLOCKS);
        else
            cfg_eff.total = total_reg;
    end

    assign req.ready = !full;

    // Drop an empty batch allocate here: it gives no result.
    assign push = req.valid && !full &&
                  !(req.func == FN_BALLOC && req.batch_count == '0);

    always_comb
    begin
        cmd.op        = req.func;
        cmd.off       = req.target_address - base_reg;
        cmd.bad_addr  = (req.target_address == '0) || (req.target_address < base_reg);
        cmd.count     = (32'(req.batch_count) > 32'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH)
                                                              : req.batch_count;
        cmd.last_elem = req.batch_end;
    end

endmodule

`default_nettype wire

@@ rtl/bbpa_fifo.sv @@
// Short command queue between the front end and the execution back end.
// Depends on bbpa_pkg.
`default_nettype none

module bbpa_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  bbpa_pkg::cmd_t      wdata,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output bbpa_pkg::cmd_t      rdata
);
    import bbpa_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full  = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (fill_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbpa_back.sv @@
// Back end: used map, first-free search, block address multiply,
// shift-subtract divider for free checks, and the result register.
// Depends on bbpa_pkg and bbpa_if.
`default_nettype none

module bbpa_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  bbpa_pkg::cfg_t     cfg_eff,
    input  bbpa_pkg::cmd_t     cmd,
    input  wire logic          empty,
    output logic               pop,
    bbpa_rsp_if.source         rsp
);
    import bbpa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FREE = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         after_reg;
    logic [31:0]        map_reg [MAP_WORDS];
    logic [TOTAL_W-1:0] used_reg;
    logic [BATCH_W-1:0] freed_reg;

    logic [2:0]         op_reg;
    logic [BATCH_W-1:0] count_reg;
    logic [BATCH_W-1:0] k_reg;
    logic               end_reg;
    logic [ADDR_W-1:0]  rem_reg;
    logic [DSH_W-1:0]   dsh_reg;
    logic [IDX_W-1:0]   q_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]  prod_reg;
    logic [LIM_W-1:0]   lim_reg;

    logic               res_ok_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [BATCH_W-1:0] res_total_reg;
    logic               res_last_reg;

    logic               ov_reg;
    logic               o_ok_reg;
    logic [ADDR_W-1:0]  o_addr_reg;
    logic [TOTAL_W-1:0] o_inuse_reg;
    logic [BATCH_W-1:0] o_total_reg;
    logic               o_last_reg;

    // First-free search over the map.
    logic [MAP_WORDS-1:0] not_full;
    logic                 any_free;
    logic [WSEL_W-1:0]    free_word;
    logic [WSEL_W-1:0]    rd_sel;
    logic [31:0]          rd_word;
    logic [4:0]           free_bit;
    logic [IDX_W-1:0]     free_idx;
    logic                 found;

    always_comb
    begin
        any_free  = 1'b0;
        free_word = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--)
        begin
            not_full[w] = ~&map_reg[w];
            if (not_full[w])
            begin
                any_free  = 1'b1;
                free_word = WSEL_W'(w);
            end
        end
    end

    // One map read port, shared by the search and the free check.
    assign rd_sel  = (state_reg == S_FREE) ? q_reg[IDX_W-1:5] : free_word;
    assign rd_word = map_reg[rd_sel];

    always_comb
    begin
        free_bit = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (!rd_word[b])
                free_bit = 5'(b);
        end
    end

    assign free_idx = {free_word, free_bit};
    assign found    = any_free && (32'(free_idx) < 32'(cfg_eff.total));

    // Free completion: taken on an early reject or after the divide.
    logic               free_done;
    logic               free_ok;
    logic [BATCH_W-1:0] freed_inc;
    logic               early_bad;
    logic               div_ge;
    logic [BATCH_W-1:0] k_inc;
    logic               grant_last;
    logic               slot_free;

    assign early_bad = cmd.bad_addr || (cmd.off >= 32'(lim_reg));
    assign free_done = (state_reg == S_FREE) ||
                       (state_reg == S_IDLE && !empty &&
                        (cmd.op == FN_FREE || cmd.op == FN_BFREE) && early_bad);
    assign free_ok   = (state_reg == S_FREE) && (rem_reg == '0) && rd_word[q_reg[4:0]];
    assign freed_inc = (free_ok && freed_reg < BATCH_W'(127)) ? freed_reg + 1'b1 : freed_reg;
    assign div_ge    = 48'(rem_reg) >= 48'(dsh_reg);
    assign k_inc     = k_reg + 1'b1;
    assign grant_last = (op_reg == FN_ALLOC) || (k_inc == count_reg) || !found;
    assign slot_free = !ov_reg || rsp.ready;
    assign pop       = (state_reg == S_IDLE) && !empty;

    always_ff @(posedge clk)
    begin
        lim_reg <= LIM_W'(cfg_eff.total) * LIM_W'(cfg_eff.size);
        case (state_reg)
            S_IDLE:
            begin
                op_reg    <= cmd.op;
                count_reg <= cmd.count;
                end_reg   <= cmd.last_elem;
                k_reg     <= '0;
                rem_reg   <= cmd.off;
                dsh_reg   <= DSH_W'(cfg_eff.size) << (IDX_W - 1);
                q_reg     <= '0;
                step_reg  <= '0;
            end
            S_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_reg - ADDR_W'(dsh_reg);
                q_reg    <= {q_reg[IDX_W-2:0], div_ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + 1'b1;
            end
            S_FIND:
                idx_reg <= free_idx;
            S_MUL:
                prod_reg <= ADDR_W'(idx_reg * cfg_eff.size);
            S_CHK:
                k_reg <= k_inc;
            default: ;
        endcase

        // Result staging.
        if (free_done)
        begin
            res_ok_reg    <= free_ok;
            res_addr_reg  <= '0;
            res_total_reg <= (op_reg == FN_BFREE && state_reg == S_FREE) ||
                             (cmd.op == FN_BFREE && state_reg == S_IDLE) ? freed_inc : '0;
            res_last_reg  <= 1'b1;
        end
        else if (state_reg == S_IDLE)
        begin
            res_ok_reg    <= (cmd.op == FN_RESET);
            res_addr_reg  <= '0;
            res_total_reg <= '0;
            res_last_reg  <= 1'b1;
        end
        else if (state_reg == S_FIND && !found)
        begin
            res_ok_reg    <= 1'b0;
            res_addr_reg  <= '0;
            res_total_reg <= '0;
            res_last_reg  <= 1'b1;
        end
        else if (state_reg == S_CHK)
        begin
            res_ok_reg    <= 1'b1;
            res_addr_reg  <= cfg_eff.base + prod_reg;
            res_total_reg <= (op_reg == FN_ALLOC) ? '0 : k_inc;
            res_last_reg  <= grant_last;
        end

        if (state_reg == S_OUT && slot_free)
        begin
            o_ok_reg    <= res_ok_reg;
            o_addr_reg  <= res_addr_reg;
            o_inuse_reg <= used_reg;
            o_total_reg <= res_total_reg;
            o_last_reg  <= res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            used_reg  <= '0;
            freed_reg <= '0;
            ov_reg    <= 1'b0;
            for (int w = 0; w < MAP_WORDS; w++)
                map_reg[w] <= '0;
        end
        else
        begin
            if (free_done)
            begin
                if (free_ok)
                begin
                    map_reg[q_reg[IDX_W-1:5]][q_reg[4:0]] <= 1'b0;
                    if (used_reg != '0)
                        used_reg <= used_reg - 1'b1;
                end
                if ((state_reg == S_FREE && op_reg == FN_BFREE) ||
                    (state_reg == S_IDLE && cmd.op == FN_BFREE))
                begin
                    if ((state_reg == S_FREE) ? end_reg : cmd.last_elem)
                        freed_reg <= '0;
                    else
                        freed_reg <= freed_inc;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        after_reg <= S_IDLE;
                        case (cmd.op)
                            FN_ALLOC, FN_BALLOC:
                                state_reg <= S_FIND;
                            FN_FREE, FN_BFREE:
                                state_reg <= early_bad ? S_OUT : S_DIV;
                            FN_RESET:
                            begin
                                for (int w = 0; w < MAP_WORDS; w++)
                                    map_reg[w] <= '0;
                                used_reg  <= '0;
                                state_reg <= S_OUT;
                            end
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (found)
                    begin
                        map_reg[free_word][free_bit] <= 1'b1;
                        used_reg  <= used_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        after_reg <= S_IDLE;
                        state_reg <= S_OUT;
                    end
                end
                S_MUL:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    // Look one grant ahead so the final grant carries the last mark.
                    after_reg <= grant_last ? S_IDLE : S_FIND;
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (step_reg == STEP_W'(IDX_W - 1))
                        state_reg <= S_FREE;
                end
                S_FREE:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (slot_free)
                        state_reg <= after_reg;
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (state_reg == S_OUT && slot_free)
                ov_reg <= 1'b1;
            else if (rsp.ready)
                ov_reg <= 1'b0;
        end
    end

    assign rsp.valid           = ov_reg;
    assign rsp.ok              = o_ok_reg;
    assign rsp.granted_address = o_addr_reg;
    assign rsp.blocks_in_use   = o_inuse_reg;
    assign rsp.batch_total     = o_total_reg;
    assign rsp.run_last        = o_last_reg;

endmodule

`default_nettype wire

@@ rtl/bitmap_block_pool_allocator.sv @@
// Top level of the bitmap block pool allocator: front end, command queue, back end.
// Depends on bbpa_pkg, bbpa_if, bbpa_front, bbpa_fifo and bbpa_back.
//
//   port  | direction | carries
//   ------+-----------+---------------------------------------------------------
//   req   | in        | func, target_address, batch_count, batch_end
//   rsp   | out       | ok, granted_address, blocks_in_use, batch_total, run_last
//   cfg   | in        | index (0 pool_base, 1 block_bytes, 2 block_total), data
//
// Allocate runs pop, search, multiply, look-ahead and output from queue head to result
// register; each further block of a batch repeats search through output. Free runs pop,
// the 10-step shift-subtract divider, map check and output; rejected addresses skip the
// divider. Reset clears the used map at once; no clearing pass. A 2-entry command queue
// lets requests be taken while the back end works or the result waits.
`default_nettype none

module bitmap_block_pool_allocator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bbpa_req_if.sink   req,
    bbpa_rsp_if.source rsp,
    bbpa_cfg_if.sink   cfg
);
    import bbpa_pkg::*;

    cfg_t cfg_eff;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic push;
    logic full;
    logic pop;
    logic empty;

    bbpa_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cfg     (cfg),
        .cfg_eff (cfg_eff),
        .cmd     (cmd_in),
        .push    (push),
        .full    (full)
    );

    bbpa_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (cmd_out)
    );

    bbpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_eff (cfg_eff),
        .cmd     (cmd_out),
        .empty   (empty),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/bbpa_checker.sv @@
// Port-level checks on the result channel of the allocator, bound to the top level.
// Depends on bbpa_pkg.
`default_nettype none

module bbpa_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         valid,
    input wire logic                         ready,
    input wire logic                         ok,
    input wire logic [bbpa_pkg::ADDR_W-1:0]  granted_address,
    input wire logic [bbpa_pkg::TOTAL_W-1:0] blocks_in_use,
    input wire logic [bbpa_pkg::BATCH_W-1:0] batch_total,
    input wire logic                         run_last
);
    import bbpa_pkg::*;

    // A failed result never carries an address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ok |-> granted_address == '0)
        else $error("failed result carries an address");

    // A failed result always closes its run.
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ok |-> run_last)
        else $error("failed result does not end its run");

    // The used count never exceeds the map size.
    a_inuse_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> 32'(blocks_in_use) <= 32'(MAX_BLOCKS))
        else $error("blocks_in_use above map size");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(granted_address) && $stable(batch_total)
                            && $stable(ok) && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind bitmap_block_pool_allocator bbpa_checker u_bbpa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (rsp.valid),
    .ready           (rsp.ready),
    .ok              (rsp.ok),
    .granted_address (rsp.granted_address),
    .blocks_in_use   (rsp.blocks_in_use),
    .batch_total     (rsp.batch_total),
    .run_last        (rsp.run_last)
);

`default_nettype wire
